// ----- hw/rtl/gdr_pkg.sv -----
// ----------------------------------------------------------------------------
// gdr_pkg
// shared types, widths and codes of the grid ray caster
// ----------------------------------------------------------------------------
package gdr_pkg;

	localparam int POS_W   = 16;
	localparam int DIR_W   = 16;
	localparam int DIM_W   = 11;
	localparam int COL_W   = 10;
	localparam int CXY_W   = 5;
	localparam int CODE_W  = 4;
	localparam int DIST_W  = 16;
	localparam int TEX_W   = 6;
	localparam int LH_W    = 11;
	localparam int SPAN_W  = 10;
	localparam int RAY_W   = 18;
	localparam int DELTA_W = 41;
	localparam int SD_W    = 48;
	localparam int MC_W    = 8;
	localparam int FX_W    = 12;
	localparam int FRAC_W  = 30;
	localparam int DVD_W   = 31;
	localparam int DVS_W   = 48;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DAT_W = 16;

	localparam logic [DIM_W-1:0]   MAX_DIM    = 11'd1024;
	localparam logic [LH_W-1:0]    LH_MAX     = 11'd2047;
	localparam logic [DELTA_W-1:0] DELTA_INF  = 41'h100_0000_0000;
	localparam logic [DVD_W-1:0]   DVD_ONE_Q30 = 31'h4000_0000;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_PLAYER_X = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PLAYER_Y = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DIR_X    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_DIR_Y    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_PLANE_X  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_PLANE_Y  = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_SCREEN_W = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_SCREEN_H = 3'd7;

	// register reset values
	localparam logic [POS_W-1:0] RST_PLAYER_X = 16'd5120;
	localparam logic [POS_W-1:0] RST_PLAYER_Y = 16'd15360;
	localparam logic [DIR_W-1:0] RST_DIR_X    = 16'd16384;
	localparam logic [DIR_W-1:0] RST_DIR_Y    = 16'd0;
	localparam logic [DIR_W-1:0] RST_PLANE_X  = 16'd0;
	localparam logic [DIR_W-1:0] RST_PLANE_Y  = 16'd9459;
	localparam logic [DIM_W-1:0] RST_SCREEN_W = 11'd640;
	localparam logic [DIM_W-1:0] RST_SCREEN_H = 11'd480;

	// input word kinds
	localparam logic KIND_WRITE = 1'b0;
	localparam logic KIND_CAST  = 1'b1;

	// divider operand selection
	localparam logic [1:0] DIV_CAM = 2'd0;
	localparam logic [1:0] DIV_DX  = 2'd1;
	localparam logic [1:0] DIV_DY  = 2'd2;
	localparam logic [1:0] DIV_LH  = 2'd3;

	typedef struct packed {
		logic               kind;
		logic [COL_W-1:0]   column;
		logic [CXY_W-1:0]   cell_x;
		logic [CXY_W-1:0]   cell_y;
		logic [CODE_W-1:0]  cell_value;
	} cast_item_t;

	typedef struct packed {
		logic [COL_W-1:0]   column_out;
		logic [DIST_W-1:0]  wall_distance;
		logic               hit_side;
		logic [CXY_W-1:0]   hit_x;
		logic [CXY_W-1:0]   hit_y;
		logic [CODE_W-1:0]  wall_code;
		logic               off_map;
		logic [TEX_W-1:0]   tex_column;
		logic [LH_W-1:0]    line_height;
		logic [SPAN_W-1:0]  draw_start;
		logic [SPAN_W-1:0]  draw_end;
	} res_item_t;

	typedef struct packed {
		logic [CFG_IDX_W-1:0] index;
		logic [CFG_DAT_W-1:0] wdata;
	} cfg_item_t;

	typedef struct packed {
		logic       wr_cell;
		logic       ld_col;
		logic       div_start;
		logic [1:0] div_sel;
		logic       ld_cam;
		logic       ld_ray;
		logic       ld_dx;
		logic       ld_dy;
		logic       ld_side;
		logic       step;
		logic       check;
		logic       ld_fin;
		logic       ld_tex;
		logic       ld_lh;
		logic       ld_out;
	} gdr_cmd_t;

	typedef struct packed {
		logic clr_busy;
		logic cast_ok;
		logic div_busy;
		logic div_done;
		logic stop;
		logic hit;
		logic out_free;
	} gdr_sts_t;

	// zero is used as one, anything above 1024 as 1024
	function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v);
		logic [DIM_W-1:0] r;
		r = v;
		if (v == '0)
			r = DIM_W'(1);
		else if (v > MAX_DIM)
			r = MAX_DIM;
		return r;
	endfunction

endpackage

// ----- hw/rtl/gdr_ifs.sv -----
// ----------------------------------------------------------------------------
// gdr_ifs
// valid/ready channels of the grid ray caster
// ----------------------------------------------------------------------------
interface gdr_cast_if import gdr_pkg::*; ();
	logic       valid;
	logic       ready;
	cast_item_t data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface gdr_res_if import gdr_pkg::*; ();
	logic      valid;
	logic      ready;
	res_item_t data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface gdr_cfg_if import gdr_pkg::*; ();
	logic      valid;
	logic      ready;
	cfg_item_t data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// ----- hw/rtl/gdr_div.sv -----
// ----------------------------------------------------------------------------
// gdr_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module gdr_div import gdr_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DVD_W-1:0] dividend,
	input  logic [DVS_W-1:0] divisor,
	output logic             busy,
	output logic             done,
	output logic [DVD_W-1:0] quotient
);

	localparam int CNT_W = $clog2(DVD_W + 1);

	logic             busy_q, done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DVS_W-1:0] rem_q, dvs_q;
	logic [DVD_W-1:0] quo_q;
	logic [DVS_W:0]   trial, diff;
	logic             ge;

	assign trial = {rem_q, quo_q[DVD_W-1]};
	assign ge    = trial >= {1'b0, dvs_q};
	assign diff  = trial - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= CNT_W'(DVD_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - CNT_W'(1);
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
			quo_q <= {quo_q[DVD_W-2:0], ge};
		end
	end

	assign busy     = busy_q;
	assign done     = done_q;
	assign quotient = quo_q;

	a_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !busy_q) else $error("divider restarted while busy");
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q) else $error("divider done longer than one cycle");
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(done_q) |-> $past(busy_q)) else $error("done without a division");

endmodule

// ----- hw/rtl/gdr_ctrl.sv -----
// ----------------------------------------------------------------------------
// gdr_ctrl
// sequencer of map writes and of one cast: camera, ray, deltas, dda walk, projection
// ----------------------------------------------------------------------------
module gdr_ctrl import gdr_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	input  logic     in_kind,
	output logic     in_ready,
	input  gdr_sts_t sts,
	output gdr_cmd_t cmd
);

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_CAMST = 4'd1;
	localparam logic [3:0] S_CAM   = 4'd2;
	localparam logic [3:0] S_RAY   = 4'd3;
	localparam logic [3:0] S_DXST  = 4'd4;
	localparam logic [3:0] S_DX    = 4'd5;
	localparam logic [3:0] S_DYST  = 4'd6;
	localparam logic [3:0] S_DY    = 4'd7;
	localparam logic [3:0] S_SIDE  = 4'd8;
	localparam logic [3:0] S_STEP  = 4'd9;
	localparam logic [3:0] S_READ  = 4'd10;
	localparam logic [3:0] S_FIN   = 4'd11;
	localparam logic [3:0] S_LHST  = 4'd12;
	localparam logic [3:0] S_LH    = 4'd13;
	localparam logic [3:0] S_OUT   = 4'd14;

	logic [3:0] state_q, state_d;
	logic       accept;

	assign in_ready = (state_q == S_IDLE) && !sts.clr_busy;
	assign accept   = in_valid && in_ready;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				if (accept && in_kind == KIND_WRITE)
					cmd.wr_cell = 1'b1;
				if (accept && in_kind == KIND_CAST && sts.cast_ok) begin
					cmd.ld_col = 1'b1;
					state_d    = S_CAMST;
				end
			end
			S_CAMST: begin
				cmd.div_start = 1'b1;
				cmd.div_sel   = DIV_CAM;
				state_d       = S_CAM;
			end
			S_CAM: begin
				if (sts.div_done) begin
					cmd.ld_cam = 1'b1;
					state_d    = S_RAY;
				end
			end
			S_RAY: begin
				cmd.ld_ray = 1'b1;
				state_d    = S_DXST;
			end
			S_DXST: begin
				cmd.div_start = 1'b1;
				cmd.div_sel   = DIV_DX;
				state_d       = S_DX;
			end
			S_DX: begin
				if (sts.div_done) begin
					cmd.ld_dx = 1'b1;
					state_d   = S_DYST;
				end
			end
			S_DYST: begin
				cmd.div_start = 1'b1;
				cmd.div_sel   = DIV_DY;
				state_d       = S_DY;
			end
			S_DY: begin
				if (sts.div_done) begin
					cmd.ld_dy = 1'b1;
					state_d   = S_SIDE;
				end
			end
			S_SIDE: begin
				cmd.ld_side = 1'b1;
				state_d     = S_STEP;
			end
			S_STEP: begin
				cmd.step = 1'b1;
				state_d  = sts.stop ? S_FIN : S_READ;
			end
			S_READ: begin
				cmd.check = 1'b1;
				state_d   = sts.hit ? S_FIN : S_STEP;
			end
			S_FIN: begin
				cmd.ld_fin = 1'b1;
				state_d    = S_LHST;
			end
			S_LHST: begin
				cmd.div_start = 1'b1;
				cmd.div_sel   = DIV_LH;
				cmd.ld_tex    = 1'b1;
				state_d       = S_LH;
			end
			S_LH: begin
				if (sts.div_done) begin
					cmd.ld_lh = 1'b1;
					state_d   = S_OUT;
				end
			end
			S_OUT: begin
				if (sts.out_free) begin
					cmd.ld_out = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_d;
	end

	a_no_take_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		sts.clr_busy |-> !in_ready) else $error("word taken during map clear");
	a_div_idle_at_start: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_start |-> !sts.div_busy) else $error("divider started while busy");
	a_out_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.ld_out |-> sts.out_free) else $error("result overwritten");

endmodule

// ----- hw/rtl/gdr_datapath.sv -----
// ----------------------------------------------------------------------------
// gdr_datapath
// registers, map memory, divider and arithmetic of the ray caster
// ----------------------------------------------------------------------------
module gdr_datapath import gdr_pkg::*; #(
	parameter int MAP_SIZE     = 32,
	parameter int TEX_SIZE     = 64,
	parameter int FAR_DISTANCE = 4096
) (
	input  logic       clk,
	input  logic       arst_n,
	input  gdr_cmd_t   cmd,
	output gdr_sts_t   sts,
	input  cast_item_t in_data,
	gdr_res_if.source  res,
	gdr_cfg_if.sink    cfg
);

	localparam int CW         = $clog2(MAP_SIZE);
	localparam int AW         = 2 * CW;
	localparam int DEPTH      = 1 << AW;
	localparam int STEP_LIMIT = 4 * MAP_SIZE + 64;
	localparam int STEP_W     = $clog2(STEP_LIMIT + 1);
	localparam int TIW        = $clog2(TEX_SIZE);
	localparam int TPW        = FRAC_W + TIW;

	// configuration
	logic [POS_W-1:0]        player_x_q, player_y_q;
	logic signed [DIR_W-1:0] dir_x_q, dir_y_q, plane_x_q, plane_y_q;
	logic [DIM_W-1:0]        width_q, height_q, w_eff, h_eff;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			player_x_q <= RST_PLAYER_X;
			player_y_q <= RST_PLAYER_Y;
			dir_x_q    <= RST_DIR_X;
			dir_y_q    <= RST_DIR_Y;
			plane_x_q  <= RST_PLANE_X;
			plane_y_q  <= RST_PLANE_Y;
			width_q    <= RST_SCREEN_W;
			height_q   <= RST_SCREEN_H;
		end else if (cfg.valid) begin
			case (cfg.data.index)
				REG_PLAYER_X: player_x_q <= cfg.data.wdata;
				REG_PLAYER_Y: player_y_q <= cfg.data.wdata;
				REG_DIR_X:    dir_x_q    <= cfg.data.wdata;
				REG_DIR_Y:    dir_y_q    <= cfg.data.wdata;
				REG_PLANE_X:  plane_x_q  <= cfg.data.wdata;
				REG_PLANE_Y:  plane_y_q  <= cfg.data.wdata;
				REG_SCREEN_W: width_q    <= cfg.data.wdata[DIM_W-1:0];
				REG_SCREEN_H: height_q   <= cfg.data.wdata[DIM_W-1:0];
				default: ;
			endcase
		end
	end

	assign w_eff = eff_dim(width_q);
	assign h_eff = eff_dim(height_q);

	// map memory and clearing pass
	logic              clr_busy_q;
	logic [AW-1:0]     clr_addr_q;
	logic              cell_ok, mem_we;
	logic [AW-1:0]     mem_waddr, rd_addr;
	logic [CODE_W-1:0] mem_wdata, rd_q;
	logic [CODE_W-1:0] map_mem [DEPTH];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_busy_q) begin
			clr_addr_q <= clr_addr_q + AW'(1);
			if (clr_addr_q == AW'(DEPTH - 1))
				clr_busy_q <= 1'b0;
		end
	end

	assign cell_ok   = (int'(in_data.cell_x) < MAP_SIZE) && (int'(in_data.cell_y) < MAP_SIZE);
	assign mem_we    = clr_busy_q || (cmd.wr_cell && cell_ok);
	assign mem_waddr = clr_busy_q ? clr_addr_q : {CW'(in_data.cell_y), CW'(in_data.cell_x)};
	assign mem_wdata = clr_busy_q ? '0 : in_data.cell_value;

	// cast registers
	logic [COL_W-1:0]          col_q;
	logic signed [DIR_W-1:0]   cam_q;
	logic signed [RAY_W-1:0]   rx_q, ry_q, rx_next, ry_next;
	logic signed [2*DIR_W-1:0] prod_x, prod_y;
	logic [RAY_W-1:0]          neg_rx, neg_ry;
	logic [RAY_W-2:0]          abs_rx, abs_ry;
	logic [DELTA_W-1:0]        dx_q, dy_q;
	logic [SD_W-1:0]           sdx_q, sdy_q, perp_q;
	logic signed [MC_W-1:0]    mx_q, my_q, nx, ny;
	logic [STEP_W-1:0]         steps_q;
	logic                      side_q, off_q;
	logic [CODE_W-1:0]         code_q;
	logic [FRAC_W-1:0]         frac_q, frac_next, frac_prod, ray30;
	logic [TIW-1:0]            tex_q, tex_raw, tex_m;
	logic [TPW-1:0]            tex_prod;
	logic [LH_W-1:0]           lh_q;
	logic [FX_W-1:0]           fx, fy;
	logic [FX_W+DVD_W-1:0]     prod_fx, prod_fy;
	logic                      less, leave, limit, mirror;
	logic [POS_W-1:0]          other_pos;
	logic signed [RAY_W-1:0]   other_ray;

	// divider
	logic [DVD_W-1:0] dvd, quo;
	logic [DVS_W-1:0] dvs;
	logic             div_busy, div_done;

	always_comb begin
		case (cmd.div_sel)
			DIV_CAM: begin
				dvd = DVD_W'({col_q, 15'd0});
				dvs = DVS_W'(w_eff);
			end
			DIV_DX: begin
				dvd = DVD_ONE_Q30;
				dvs = DVS_W'(abs_rx);
			end
			DIV_DY: begin
				dvd = DVD_ONE_Q30;
				dvs = DVS_W'(abs_ry);
			end
			DIV_LH: begin
				dvd = DVD_W'({h_eff, 16'd0});
				dvs = perp_q;
			end
			default: begin
				dvd = '0;
				dvs = '0;
			end
		endcase
	end

	gdr_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (dvd),
		.divisor  (dvs),
		.busy     (div_busy),
		.done     (div_done),
		.quotient (quo)
	);

	// ray direction
	assign prod_x  = plane_x_q * cam_q;
	assign prod_y  = plane_y_q * cam_q;
	assign rx_next = RAY_W'(dir_x_q) + RAY_W'(prod_x >>> 14);
	assign ry_next = RAY_W'(dir_y_q) + RAY_W'(prod_y >>> 14);
	assign neg_rx  = -rx_q;
	assign neg_ry  = -ry_q;
	assign abs_rx  = (rx_q < 0) ? neg_rx[RAY_W-2:0] : rx_q[RAY_W-2:0];
	assign abs_ry  = (ry_q < 0) ? neg_ry[RAY_W-2:0] : ry_q[RAY_W-2:0];

	// distance to the first grid line
	assign fx = (rx_q < 0) ? {1'b0, player_x_q[10:0]} : FX_W'(2048) - {1'b0, player_x_q[10:0]};
	assign fy = (ry_q < 0) ? {1'b0, player_y_q[10:0]} : FX_W'(2048) - {1'b0, player_y_q[10:0]};
	assign prod_fx = fx * dx_q[DVD_W-1:0];
	assign prod_fy = fy * dy_q[DVD_W-1:0];

	// dda step
	assign less  = sdx_q < sdy_q;
	assign nx    = !less ? mx_q : ((rx_q < 0) ? mx_q - MC_W'(1) : mx_q + MC_W'(1));
	assign ny    = less ? my_q : ((ry_q < 0) ? my_q - MC_W'(1) : my_q + MC_W'(1));
	assign leave = (nx < 0) || (int'(nx) >= MAP_SIZE) || (ny < 0) || (int'(ny) >= MAP_SIZE);
	assign limit = int'(steps_q) >= STEP_LIMIT;
	assign rd_addr = {CW'(ny), CW'(nx)};

	always_ff @(posedge clk) begin
		if (mem_we)
			map_mem[mem_waddr] <= mem_wdata;
		if (cmd.step)
			rd_q <= map_mem[rd_addr];
	end

	// wall coordinate
	assign other_pos = side_q ? player_x_q : player_y_q;
	assign other_ray = side_q ? rx_q : ry_q;
	assign ray30     = FRAC_W'(other_ray);
	assign frac_prod = perp_q[FRAC_W-1:0] * ray30;
	assign frac_next = {other_pos[10:0], 19'd0} + frac_prod;
	assign tex_prod  = TPW'(frac_q) * TPW'(TEX_SIZE);
	assign tex_raw   = tex_prod[TPW-1:FRAC_W];
	assign mirror    = (!side_q && rx_q > 0) || (side_q && ry_q < 0);
	assign tex_m     = mirror ? TIW'(TEX_SIZE - 1) - tex_raw : tex_raw;

	always_ff @(posedge clk) begin
		if (cmd.ld_col)
			col_q <= in_data.column;
		if (cmd.ld_cam)
			cam_q <= $signed({1'b0, quo[14:0]}) - 16'sd16384;
		if (cmd.ld_ray) begin
			rx_q <= rx_next;
			ry_q <= ry_next;
		end
		if (cmd.ld_dx)
			dx_q <= (rx_q == 0) ? DELTA_INF : DELTA_W'(quo);
		if (cmd.ld_dy)
			dy_q <= (ry_q == 0) ? DELTA_INF : DELTA_W'(quo);
		if (cmd.ld_side) begin
			sdx_q   <= (rx_q == 0) ? SD_W'({fx, 29'd0}) : SD_W'(prod_fx >> 11);
			sdy_q   <= (ry_q == 0) ? SD_W'({fy, 29'd0}) : SD_W'(prod_fy >> 11);
			mx_q    <= MC_W'(player_x_q[15:11]);
			my_q    <= MC_W'(player_y_q[15:11]);
			steps_q <= '0;
			side_q  <= 1'b0;
			off_q   <= 1'b0;
		end
		if (cmd.step) begin
			if (limit) begin
				off_q <= 1'b1;
			end else begin
				if (less) begin
					sdx_q  <= sdx_q + SD_W'(dx_q);
					perp_q <= sdx_q;
					side_q <= 1'b0;
				end else begin
					sdy_q  <= sdy_q + SD_W'(dy_q);
					perp_q <= sdy_q;
					side_q <= 1'b1;
				end
				mx_q    <= nx;
				my_q    <= ny;
				steps_q <= steps_q + STEP_W'(1);
				off_q   <= leave;
			end
		end
		if (cmd.check && rd_q != '0)
			code_q <= rd_q;
		if (cmd.ld_fin) begin
			frac_q <= frac_next;
			if (off_q)
				perp_q <= SD_W'(FAR_DISTANCE) << 8;
		end
		if (cmd.ld_tex)
			tex_q <= tex_m;
		if (cmd.ld_lh)
			lh_q <= (|quo[DVD_W-1:LH_W]) ? LH_MAX : quo[LH_W-1:0];
	end

	// projection and result register
	logic [SPAN_W-1:0] hh, lh2, ds;
	logic [DIM_W-1:0]  de_sum, h_m1;
	logic [DIST_W-1:0] wall_dist;
	logic              out_valid_q;
	res_item_t         res_q;

	assign hh     = h_eff[DIM_W-1:1];
	assign lh2    = lh_q[LH_W-1:1];
	assign ds     = (hh > lh2) ? hh - lh2 : '0;
	assign de_sum = {1'b0, hh} + {1'b0, lh2};
	assign h_m1   = h_eff - DIM_W'(1);
	assign wall_dist = off_q ? DIST_W'(FAR_DISTANCE) :
		((|perp_q[SD_W-1:24]) ? {DIST_W{1'b1}} : perp_q[23:8]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.ld_out)
			out_valid_q <= 1'b1;
		else if (res.ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.ld_out) begin
			res_q.column_out    <= col_q;
			res_q.wall_distance <= wall_dist;
			res_q.hit_side      <= side_q;
			res_q.hit_x         <= off_q ? '0 : CXY_W'(mx_q);
			res_q.hit_y         <= off_q ? '0 : CXY_W'(my_q);
			res_q.wall_code     <= off_q ? '0 : code_q;
			res_q.off_map       <= off_q;
			res_q.tex_column    <= off_q ? '0 : TEX_W'(tex_q);
			res_q.line_height   <= lh_q;
			res_q.draw_start    <= ds;
			res_q.draw_end      <= (de_sum > h_m1) ? h_m1[SPAN_W-1:0] : de_sum[SPAN_W-1:0];
		end
	end

	assign res.valid = out_valid_q;
	assign res.data  = res_q;

	assign sts.clr_busy = clr_busy_q;
	assign sts.cast_ok  = {1'b0, in_data.column} < w_eff;
	assign sts.div_busy = div_busy;
	assign sts.div_done = div_done;
	assign sts.stop     = limit || leave;
	assign sts.hit      = rd_q != '0;
	assign sts.out_free = !out_valid_q || res.ready;

	a_no_write_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		clr_busy_q |-> !cmd.wr_cell) else $error("cell write during clear");
	a_step_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.step |-> int'(steps_q) <= STEP_LIMIT) else $error("step count overran");
	a_result_after_lh: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.ld_lh |-> !div_busy) else $error("line height taken from busy divider");

endmodule

// ----- hw/rtl/grid_dda_ray_caster.sv -----
// ----------------------------------------------------------------------------
// grid_dda_ray_caster
// grid map of wall codes and per-column dda ray caster
// ----------------------------------------------------------------------------
// A word on cast_in either writes one map cell (kind 0, no result) or casts
// one screen column (kind 1). A cast walks the ray cell by cell from the
// player position and returns one result word with distance, face, cell,
// wall code, texture column and draw span; a column at or beyond the screen
// width returns nothing. The ray crosses at most 4*MAP_SIZE+64 grid cells.
// Four divisions run one quotient bit per cycle on a shared 31-bit divider,
// and each dda step is a step state followed by a registered map read. A
// finished result waits in the output register while the next word is
// taken. After reset the map is cleared one cell a cycle, all
// 2^(2*ceil(log2 MAP_SIZE)) cells (1024 at the default size), and cast_in
// holds ready low meanwhile; configuration writes are taken at any time but
// should only be made while the block is idle.
// ----------------------------------------------------------------------------
module grid_dda_ray_caster import gdr_pkg::*; #(
	parameter int MAP_SIZE     = 32,
	parameter int TEX_SIZE     = 64,
	parameter int FAR_DISTANCE = 4096
) (
	input  logic       clk,
	input  logic       arst_n,
	gdr_cast_if.sink   cast_in,
	gdr_res_if.source  result_out,
	gdr_cfg_if.sink    cfg
);

	// command and status between sequencer and datapath
	gdr_cmd_t cmd;
	gdr_sts_t sts;
	logic     in_ready;

	// ready comes from the sequencer, gated by the map clear status of the datapath
	assign cast_in.ready = in_ready;

	gdr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (cast_in.valid),
		.in_kind  (cast_in.data.kind),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// map, registers, divider and result word
	gdr_datapath #(
		.MAP_SIZE     (MAP_SIZE),
		.TEX_SIZE     (TEX_SIZE),
		.FAR_DISTANCE (FAR_DISTANCE)
	) u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.sts     (sts),
		.in_data (cast_in.data),
		.res     (result_out),
		.cfg     (cfg)
	);

endmodule
